FILE: hdl/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// shared types, constants and tables for the aes-128 encryption unit
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int HALF_W   = 64;
  localparam int BLOCK_W  = 128;
  localparam int RND_W    = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [RND_W-1:0] LAST_ROUND = 4'd9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;

  typedef struct packed {
    logic [HALF_W-1:0] plain_high;
    logic [HALF_W-1:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [HALF_W-1:0] cipher_high;
    logic [HALF_W-1:0] cipher_low;
  } cipher_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic [RND_W-1:0] rnd;
  } cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
    8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
    8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
    8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
    8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
    8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
    8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
    8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
    8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
    8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
    8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
    8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
    8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
    8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
    8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
    8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // round constant for key expansion
  function automatic logic [7:0] rcon(input logic [RND_W-1:0] rnd);
    logic [7:0] rc;
    unique case (rnd)
      4'd0:    rc = 8'h01;
      4'd1:    rc = 8'h02;
      4'd2:    rc = 8'h04;
      4'd3:    rc = 8'h08;
      4'd4:    rc = 8'h10;
      4'd5:    rc = 8'h20;
      4'd6:    rc = 8'h40;
      4'd7:    rc = 8'h80;
      4'd8:    rc = 8'h1B;
      4'd9:    rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  // multiply by x in gf(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1B) : {v[6:0], 1'b0};
  endfunction

endpackage

FILE: hdl/aes_ctrl.sv
// ----------------------------------------------------------------------------
// aes_ctrl
// round sequencer and result handshake for the aes-128 encryption unit
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output aes_pkg::cmd_t     cmd
);

  aes_pkg::state_t               state_r, state_nxt;
  logic [aes_pkg::RND_W-1:0]     rnd_r, rnd_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          last;
  logic                          out_free;
  logic                          accept;
  logic                          step;

  assign last     = (rnd_r == aes_pkg::LAST_ROUND);
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aes_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = aes_pkg::ST_RUN;
      end
      aes_pkg::ST_RUN: begin
        if (last && out_free) state_nxt = aes_pkg::ST_IDLE;
      end
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    accept = 1'b0;
    step   = 1'b0;
    unique case (state_r)
      aes_pkg::ST_IDLE: begin
        accept = in_valid;
      end
      aes_pkg::ST_RUN: begin
        // last round waits until the output register is free
        step = !last || out_free;
      end
      default: begin
        accept = 1'b0;
        step   = 1'b0;
      end
    endcase
  end

  always_comb begin
    rnd_nxt = rnd_r;
    if (accept) rnd_nxt = '0;
    else if (step && !last) rnd_nxt = rnd_r + 1'b1;

    if (step && last) out_valid_nxt = 1'b1;
    else out_valid_nxt = out_valid_r && out_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aes_pkg::ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != aes_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.load  = accept;
  assign cmd.step  = step;
  assign cmd.rnd   = rnd_r;

endmodule

FILE: hdl/aes_datapath.sv
// ----------------------------------------------------------------------------
// aes_datapath
// key registers, state and round key registers and one full round of logic
// ----------------------------------------------------------------------------
module aes_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aes_pkg::HALF_W-1:0]    cfg_data,
  input  aes_pkg::plain_t               in_data,
  input  aes_pkg::cmd_t                 cmd,
  output aes_pkg::cipher_t              out_data
);

  logic [aes_pkg::HALF_W-1:0]  key_high_r, key_low_r;
  logic [aes_pkg::BLOCK_W-1:0] st_r, rk_r;
  logic [aes_pkg::BLOCK_W-1:0] round_st, round_rk;
  logic [aes_pkg::BLOCK_W-1:0] key;
  aes_pkg::cipher_t            out_r;

  logic [7:0] st_b [16];
  logic [7:0] rk_b [16];
  logic [7:0] sb   [16];
  logic [7:0] mx   [16];
  logic [7:0] nk   [16];
  logic [7:0] rc;
  logic       last;

  assign key  = {key_high_r, key_low_r};
  assign last = (cmd.rnd == aes_pkg::LAST_ROUND);
  assign rc   = aes_pkg::rcon(cmd.rnd);

  // byte 0 is the top byte, state is column major
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      st_b[i] = st_r[aes_pkg::BLOCK_W-1-8*i -: 8];
      rk_b[i] = rk_r[aes_pkg::BLOCK_W-1-8*i -: 8];
    end
  end

  // subbytes and shiftrows
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r+4*c] = aes_pkg::sbox(st_b[r+4*((c+r)&3)]);
      end
    end
  end

  // mixcolumns
  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = sb[4*c];
      a1 = sb[4*c+1];
      a2 = sb[4*c+2];
      a3 = sb[4*c+3];
      mx[4*c]   = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
      mx[4*c+1] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
      mx[4*c+2] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
      mx[4*c+3] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
    end
  end

  // next round key, rotword and subword on the last word
  always_comb begin
    nk[0] = rk_b[0] ^ aes_pkg::sbox(rk_b[13]) ^ rc;
    nk[1] = rk_b[1] ^ aes_pkg::sbox(rk_b[14]);
    nk[2] = rk_b[2] ^ aes_pkg::sbox(rk_b[15]);
    nk[3] = rk_b[3] ^ aes_pkg::sbox(rk_b[12]);
    for (int i = 4; i < 16; i++) begin
      nk[i] = rk_b[i] ^ nk[i-4];
    end
  end

  // addroundkey, final round skips mixcolumns
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      round_st[aes_pkg::BLOCK_W-1-8*i -: 8] = (last ? sb[i] : mx[i]) ^ nk[i];
      round_rk[aes_pkg::BLOCK_W-1-8*i -: 8] = nk[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aes_pkg::CFG_KEY_HIGH: key_high_r <= cfg_data;
        aes_pkg::CFG_KEY_LOW:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r <= {in_data.plain_high, in_data.plain_low} ^ key;
      rk_r <= key;
    end else if (cmd.step) begin
      if (last) begin
        out_r <= round_st;
      end else begin
        st_r <= round_st;
        rk_r <= round_rk;
      end
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/aes128_block_encrypt_unit.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt_unit
// aes-128 block encryption, one round per cycle unless output is held, on-the-fly key schedule
// ----------------------------------------------------------------------------
// latency: out_valid rises after the ten rounds that follow the accepting edge (the
//   initial key add rides on the load); the last round waits for a free output register
// throughput: a new block is accepted only when idle, after the load and ten passes of
//   the state register through the single shared round unit
// a finished block waits in the output register while the next one runs
// reset: synchronous, active low; clears the sequencer, the output valid and
//   both key registers (the key reads as all zero until written)
// ----------------------------------------------------------------------------
module aes128_block_encrypt_unit (
  input  logic                          clk,
  input  logic                          rst_n,

  // configuration write port, always ready
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aes_pkg::HALF_W-1:0]    cfg_data,

  // plaintext items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  aes_pkg::plain_t               in_data,

  // ciphertext items
  output logic                          out_valid,
  input  logic                          out_stall,
  output aes_pkg::cipher_t              out_data
);

  aes_pkg::cmd_t cmd;
  logic          cfg_we;

  // key writes must be made only while idle; the block itself does not enforce this, no interlock
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // sequencer: accepts an item when idle, steps the round counter, holds
  // the last round until the output register is free
  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: key registers, state, round key and the round logic
  aes_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
